// ===== rtl/acso_pkg.sv =====
// Package with the widths, register indexes and constants of the ADC scan oversampler.
`default_nettype none
package acso_pkg;

    localparam int INPUT_BITS  = 10;
    localparam int OUTPUT_BITS = 12;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 7;
    localparam int LOG2_W      = 3;
    localparam int MUX_W       = 4;
    localparam int MAP_W       = 64;
    localparam int POS_OUT_W   = 4;
    localparam int SHIFT_W     = 5;

    localparam logic [LOG2_W-1:0] MAX_LOG2   = 3'd6;
    localparam logic [LOG2_W-1:0] RST_LOG2   = 3'd4;
    localparam logic [MAP_W-1:0]  RST_MAP    = 64'h0000_0000_7654_3210;

    typedef enum logic [0:0] {
        CFG_SAMPLE_LOG2 = 1'b0,
        CFG_CHANNEL_MAP = 1'b1
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== rtl/acso_sample_if.sv =====
// Input channel carrying one finished conversion per item.
`default_nettype none
interface acso_sample_if;
    logic                         valid;
    logic                         ready;
    logic [acso_pkg::INPUT_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/acso_result_if.sv =====
// Output channel carrying one scan result per item.
`default_nettype none
interface acso_result_if;
    logic                              valid;
    logic                              ready;
    logic                              value_ready;
    logic [acso_pkg::POS_OUT_W-1:0]    done_position;
    logic [acso_pkg::OUTPUT_BITS-1:0]  scaled_value;
    logic [acso_pkg::MUX_W-1:0]        next_mux;

    modport source (output valid, output value_ready, output done_position,
                    output scaled_value, output next_mux, input ready);
    modport sink   (input valid, input value_ready, input done_position,
                    input scaled_value, input next_mux, output ready);
endinterface
`default_nettype wire

// ===== rtl/acso_scale.sv =====
// Scaler that brings an oversampled sum to the output width.
`default_nettype none
module acso_scale (
    input  wire logic [acso_pkg::SUM_W-1:0]       i_sum,
    input  wire logic [acso_pkg::LOG2_W-1:0]      i_log2,
    output logic      [acso_pkg::OUTPUT_BITS-1:0] o_value
);
    import acso_pkg::*;

    localparam int WIDE_W = SUM_W + OUTPUT_BITS;

    logic [SHIFT_W-1:0] total;
    logic [WIDE_W-1:0]  wide;

    always_comb begin
        total = SHIFT_W'(INPUT_BITS) + SHIFT_W'(i_log2);
        if (total < SHIFT_W'(OUTPUT_BITS)) begin
            wide = WIDE_W'(i_sum) << (SHIFT_W'(OUTPUT_BITS) - total);
        end else if (total > SHIFT_W'(OUTPUT_BITS)) begin
            wide = WIDE_W'(i_sum) >> (total - SHIFT_W'(OUTPUT_BITS));
        end else begin
            wide = WIDE_W'(i_sum);
        end
        o_value = wide[OUTPUT_BITS-1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/adc_channel_scan_oversampler_top.sv =====
// Top level of the round-robin ADC oversampling accumulator.
// Takes one conversion per cycle and returns one result per conversion, registered in the
// cycle after the conversion is accepted. A new conversion is taken in the same cycle that
// the waiting result is taken, so a result held off by the sink stalls the input until it
// leaves. Only the current scan position accumulates, so a single sum and count serve all
// positions. The sum, scale and channel-map lookup lie between the input port and the
// result register; configure only while idle.
`default_nettype none
module adc_channel_scan_oversampler_top #(
    parameter int NUM_INPUTS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [0:0]                 i_cfg_index,
    input  wire logic [acso_pkg::MAP_W-1:0] i_cfg_data,
    acso_sample_if.sink                     i_sample,
    acso_result_if.source                   o_result
);
    import acso_pkg::*;

    localparam int POS_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_INPUTS - 1);

    logic [LOG2_W-1:0]      r_log2;
    logic [MAP_W-1:0]       r_map;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    logic                   r_out_valid;
    logic                   r_value_ready, n_value_ready;
    logic [POS_OUT_W-1:0]   r_done_pos, n_done_pos;
    logic [OUTPUT_BITS-1:0] r_value, n_value;
    logic [MUX_W-1:0]       r_mux, n_mux;

    logic                   accept;
    logic [LOG2_W-1:0]      lg;
    logic [SUM_W-1:0]       sum_add;
    logic [CNT_W-1:0]       cnt_add;
    logic                   complete;
    logic [OUTPUT_BITS-1:0] scaled;

    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    assign lg       = (r_log2 > MAX_LOG2) ? MAX_LOG2 : r_log2;
    assign sum_add  = r_sum + SUM_W'(i_sample.sample);
    assign cnt_add  = r_cnt + CNT_W'(1);
    assign complete = cnt_add >= (CNT_W'(1) << lg);

    acso_scale u_scale (
        .i_sum   (sum_add),
        .i_log2  (lg),
        .o_value (scaled)
    );

    always_comb begin
        n_sum         = sum_add;
        n_cnt         = cnt_add;
        n_pos         = r_pos;
        n_value_ready = 1'b0;
        n_done_pos    = '0;
        n_value       = '0;
        if (complete) begin
            n_sum         = '0;
            n_cnt         = '0;
            n_value_ready = 1'b1;
            n_done_pos    = POS_OUT_W'(r_pos);
            n_value       = scaled;
            n_pos         = (r_pos >= LAST_POS) ? '0 : r_pos + POS_W'(1);
        end
        n_mux = r_map[{POS_OUT_W'(n_pos), 2'b00} +: MUX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= RST_LOG2;
            r_map  <= RST_MAP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLE_LOG2: r_log2 <= i_cfg_data[LOG2_W-1:0];
                CFG_CHANNEL_MAP: r_map  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= n_pos;
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value_ready <= n_value_ready;
            r_done_pos    <= n_done_pos;
            r_value       <= n_value;
            r_mux         <= n_mux;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.value_ready   = r_value_ready;
    assign o_result.done_position = r_done_pos;
    assign o_result.scaled_value  = r_value;
    assign o_result.next_mux      = r_mux;
endmodule
`default_nettype wire
